// ===== design/assert_macros.svh =====
// assertion macros for the rtl files (included by the rgb to fixed palette index core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: label");

// antecedent on one edge implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== design/rgbpal_pkg.sv =====
// package for the rgb to fixed palette index core: constants, types, helper functions
`default_nettype none

package rgbpal_pkg;

    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int WSQ_W   = SQ_W + CHAN_W;
    localparam int INDEX_W = 12;
    localparam int NUM_CH  = 3;
    localparam int NUM_LVL = 3;
    localparam int CFG_IDX_W = 3;

    // channel slots inside the per-channel arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // cube levels
    localparam logic [CHAN_W-1:0] LEVEL_LOW  = 8'd0;
    localparam logic [CHAN_W-1:0] LEVEL_MID  = 8'd96;
    localparam logic [CHAN_W-1:0] LEVEL_HIGH = 8'd255;

    // cube index strides: i = g*9 + r*3 + b
    localparam logic [INDEX_W-1:0] STRIDE_G = 12'd9;
    localparam logic [INDEX_W-1:0] STRIDE_R = 12'd3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd6;

    // register codes
    localparam logic PALETTE_CUBE  = 1'b0;
    localparam logic PALETTE_12BIT = 1'b1;
    localparam logic MODE_DISTANCE = 1'b0;
    localparam logic MODE_CLAMP    = 1'b1;

    // reset values
    localparam logic [CHAN_W-1:0] WEIGHT_RESET   = 8'd1;
    localparam logic [CHAN_W-1:0] THRESH_LO_RESET = 8'd85;
    localparam logic [CHAN_W-1:0] THRESH_HI_RESET = 8'd170;

    typedef logic [1:0] level_sel_t;
    typedef logic [NUM_LVL-1:0][SQ_W-1:0]  sq_row_t;
    typedef logic [NUM_LVL-1:0][WSQ_W-1:0] wsq_row_t;

    function automatic logic [CHAN_W-1:0] level_of(input level_sel_t sel);
        logic [CHAN_W-1:0] lev;
        unique case (sel)
            2'd0:    lev = LEVEL_LOW;
            2'd1:    lev = LEVEL_MID;
            default: lev = LEVEL_HIGH;
        endcase
        return lev;
    endfunction

    // cube index from per-channel level selects
    function automatic logic [INDEX_W-1:0] cube_index(input level_sel_t r,
                                                      input level_sel_t g,
                                                      input level_sel_t b);
        return ({10'd0, g} * STRIDE_G) + ({10'd0, r} * STRIDE_R) + {10'd0, b};
    endfunction

    // band of one channel in clamp mode, upper test first
    function automatic level_sel_t band_of(input logic [CHAN_W-1:0] ch,
                                           input logic [CHAN_W-1:0] th_lo,
                                           input logic [CHAN_W-1:0] th_hi);
        level_sel_t band;
        priority if (ch > th_hi)
            band = 2'd2;
        else if (ch > th_lo)
            band = 2'd1;
        else
            band = 2'd0;
        return band;
    endfunction

endpackage

`default_nettype wire

// ===== design/rgb_to_fixed_palette_index_core.sv =====
// rgb to fixed palette index core: four-stage pipeline from pixel word to palette index
//
//  channel | signals                               | word
//  --------+---------------------------------------+-------------------------------
//  pixel   | s_axis_tvalid/tready/tdata[23:0]      | red, green, blue
//  index   | m_axis_tvalid/tready/tdata[15:0]      | color_index (12 bits, zero pad)
//  config  | cfg_valid/cfg_ready/cfg_index/cfg_data| register index, 8-bit value
//
// one pixel per clock while the output is not stalled; each pixel passes four registered stages:
// squared level differences, weight multiply, per-channel minimum, output register.
// the distance is separable, so the first minimum of the cube is the first minimum
// of each channel on its own. each stage holds its word until the next one frees,
// so a stall on the output loses nothing and bubbles collapse.
// reset clears the valid bits and loads the register defaults; cfg_ready stays high,
// so a config write is taken on every clock that cfg_valid is high.
`default_nettype none

module rgb_to_fixed_palette_index_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [23:0]                         s_axis_tdata,  // red, green, blue
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [15:0]                              m_axis_tdata,  // color_index, zero pad
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rgbpal_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                          cfg_data
);

`include "assert_macros.svh"

    localparam int NC = rgbpal_pkg::NUM_CH;
    localparam int NL = rgbpal_pkg::NUM_LVL;

    // configuration registers
    logic                              palette_type_reg;
    logic                              match_mode_reg;
    logic [NC-1:0][rgbpal_pkg::CHAN_W-1:0] weight_reg;
    logic [rgbpal_pkg::CHAN_W-1:0]     threshold_low_reg;
    logic [rgbpal_pkg::CHAN_W-1:0]     threshold_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_type_reg   <= rgbpal_pkg::PALETTE_CUBE;
            match_mode_reg     <= rgbpal_pkg::MODE_DISTANCE;
            weight_reg         <= {NC{rgbpal_pkg::WEIGHT_RESET}};
            threshold_low_reg  <= rgbpal_pkg::THRESH_LO_RESET;
            threshold_high_reg <= rgbpal_pkg::THRESH_HI_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rgbpal_pkg::REG_PALETTE_TYPE:   palette_type_reg <= cfg_data[0];
                rgbpal_pkg::REG_MATCH_MODE:     match_mode_reg <= cfg_data[0];
                rgbpal_pkg::REG_WEIGHT_RED:     weight_reg[rgbpal_pkg::CH_RED] <= cfg_data;
                rgbpal_pkg::REG_WEIGHT_GREEN:   weight_reg[rgbpal_pkg::CH_GREEN] <= cfg_data;
                rgbpal_pkg::REG_WEIGHT_BLUE:    weight_reg[rgbpal_pkg::CH_BLUE] <= cfg_data;
                rgbpal_pkg::REG_THRESHOLD_LOW:  threshold_low_reg <= cfg_data;
                rgbpal_pkg::REG_THRESHOLD_HIGH: threshold_high_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: squared differences to each level, plus the non-search index
    logic [NC-1:0][rgbpal_pkg::CHAN_W-1:0] pix;
    rgbpal_pkg::sq_row_t [NC-1:0]          sq_next;
    rgbpal_pkg::sq_row_t [NC-1:0]          sq1_reg;
    logic [rgbpal_pkg::INDEX_W-1:0]        alt_next;
    logic                                  use_alt_next;
    logic [rgbpal_pkg::INDEX_W-1:0]        alt1_reg;
    logic                                  use_alt1_reg;
    logic                                  cube1_reg;

    assign pix[rgbpal_pkg::CH_RED]   = s_axis_tdata[7:0];
    assign pix[rgbpal_pkg::CH_GREEN] = s_axis_tdata[15:8];
    assign pix[rgbpal_pkg::CH_BLUE]  = s_axis_tdata[23:16];

    always_comb
    begin
        logic [rgbpal_pkg::CHAN_W-1:0] lev;
        logic [rgbpal_pkg::CHAN_W-1:0] d;
        for (int c = 0; c < NC; c++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                lev = rgbpal_pkg::level_of(rgbpal_pkg::level_sel_t'(l));
                d   = (pix[c] > lev) ? (pix[c] - lev) : (lev - pix[c]);
                sq_next[c][l] = {8'd0, d} * {8'd0, d};
            end
        end
    end

    always_comb
    begin
        use_alt_next = (palette_type_reg == rgbpal_pkg::PALETTE_12BIT) ||
                       (match_mode_reg == rgbpal_pkg::MODE_CLAMP);
        if (palette_type_reg == rgbpal_pkg::PALETTE_12BIT)
            alt_next = {pix[rgbpal_pkg::CH_GREEN][7:4], pix[rgbpal_pkg::CH_BLUE][7:4],
                        pix[rgbpal_pkg::CH_RED][7:4]};
        else
            alt_next = rgbpal_pkg::cube_index(
                rgbpal_pkg::band_of(pix[rgbpal_pkg::CH_RED], threshold_low_reg,
                                    threshold_high_reg),
                rgbpal_pkg::band_of(pix[rgbpal_pkg::CH_GREEN], threshold_low_reg,
                                    threshold_high_reg),
                rgbpal_pkg::band_of(pix[rgbpal_pkg::CH_BLUE], threshold_low_reg,
                                    threshold_high_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            sq1_reg      <= sq_next;
            alt1_reg     <= alt_next;
            use_alt1_reg <= use_alt_next;
            cube1_reg    <= (palette_type_reg == rgbpal_pkg::PALETTE_CUBE);
        end
    end

    // stage 2: weight multiply
    rgbpal_pkg::wsq_row_t [NC-1:0]  wsq_next;
    rgbpal_pkg::wsq_row_t [NC-1:0]  wsq2_reg;
    logic [rgbpal_pkg::INDEX_W-1:0] alt2_reg;
    logic                           use_alt2_reg;
    logic                           cube2_reg;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            for (int l = 0; l < NL; l++)
                wsq_next[c][l] = {16'd0, weight_reg[c]} * {8'd0, sq1_reg[c][l]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            wsq2_reg     <= wsq_next;
            alt2_reg     <= alt1_reg;
            use_alt2_reg <= use_alt1_reg;
            cube2_reg    <= cube1_reg;
        end
    end

    // stage 3: first minimum per channel, then the cube index
    rgbpal_pkg::level_sel_t [NC-1:0] sel_next;
    logic [rgbpal_pkg::INDEX_W-1:0]  idx_next;
    logic [rgbpal_pkg::INDEX_W-1:0]  idx3_reg;
    logic                            cube3_reg;

    always_comb
    begin
        logic [rgbpal_pkg::WSQ_W-1:0] best;
        for (int c = 0; c < NC; c++)
        begin
            best        = wsq2_reg[c][0];
            sel_next[c] = 2'd0;
            if (wsq2_reg[c][1] < best)
            begin
                best        = wsq2_reg[c][1];
                sel_next[c] = 2'd1;
            end
            if (wsq2_reg[c][2] < best)
                sel_next[c] = 2'd2;
        end
        if (use_alt2_reg)
            idx_next = alt2_reg;
        else
            idx_next = rgbpal_pkg::cube_index(sel_next[rgbpal_pkg::CH_RED],
                                              sel_next[rgbpal_pkg::CH_GREEN],
                                              sel_next[rgbpal_pkg::CH_BLUE]);
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            idx3_reg  <= idx_next;
            cube3_reg <= cube2_reg;
        end
    end

    // stage 4: output register
    logic [rgbpal_pkg::INDEX_W-1:0] color_index_reg;
    logic                           cube4_reg;

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            color_index_reg <= idx3_reg;
            cube4_reg       <= cube3_reg;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {4'd0, color_index_reg};

    // an empty output register always lets a pixel in
    `ASSERT_ALWAYS(a_ready_when_empty, !v4_reg |-> s_axis_tready)

    // a cube word never leaves with an index past the last cube entry
    `ASSERT_ALWAYS(a_cube_range, (v4_reg && cube4_reg) |-> (color_index_reg < 12'd27))

    // a word in stage 3 that moves on shows up in the output register
    `ASSERT_NEXT(a_stage3_advance, v3_reg && en4, v4_reg)

endmodule

`default_nettype wire
